// ===== rtl/core/nccr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nccr_pkg;
    localparam int VEL_W  = 7;
    localparam int TIME_W = 32;
    localparam int OUT_W  = 34;
    localparam int LEN_W  = 24;
    localparam int DEN_W  = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

    localparam logic [CFG_IDX_W-1:0] REG_CC_NUMBER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd4;

    localparam logic [DEN_W-1:0] DENSITY_RST = 9'd21;
    localparam logic [LEN_W-1:0] ATTACK_RST  = 24'd96;
    localparam logic [LEN_W-1:0] DECAY_RST   = 24'd192;
    localparam logic [VEL_W-1:0] CC_RST      = 7'd7;

    typedef struct packed {
        logic [VEL_W-1:0]  vel;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] len;
    } t_note;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_ATK_SKIP, S_ATK_PT, S_ATK_DIV, S_VEL,
        S_DCY_PT, S_DCY_DIV, S_TAIL, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        P_HEAD, P_ATK, P_DCY, P_OTHER
    } t_phase;
endpackage
`default_nettype wire

// ===== rtl/core/nccr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface nccr_note_if;
    logic             valid;
    logic             ready;
    nccr_pkg::t_note  note_payload;
    modport source (output valid, output note_payload, input ready);
    modport sink (input valid, input note_payload, output ready);
endinterface

interface nccr_cc_if;
    logic                           valid;
    logic                           ready;
    logic [nccr_pkg::VEL_W-1:0]     cc_number;
    logic [nccr_pkg::VEL_W-1:0]     cc_value;
    logic [nccr_pkg::OUT_W-1:0]     cc_time;
    logic                           last_event;
    logic                           ramp_truncated;
    modport source (output valid, output cc_number, output cc_value, output cc_time,
                    output last_event, output ramp_truncated, input ready);
    modport sink (input valid, input cc_number, input cc_value, input cc_time,
                  input last_event, input ramp_truncated, output ready);
endinterface

interface nccr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [nccr_pkg::CFG_IDX_W-1:0]      index;
    logic [nccr_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nccr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// two-entry note queue
module nccr_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  nccr_pkg::t_note      i_note,
    output logic                 o_valid,
    input  wire                  i_ready,
    output nccr_pkg::t_note      o_note
);
    nccr_pkg::t_note r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_note  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_note;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/nccr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle; quotient saturates sanely for range*k/len
module nccr_div (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire  [31:0]  i_num,
    input  wire  [23:0]  i_den,
    output logic         o_done,
    output logic [31:0]  o_quo
);
    logic [31:0] r_num;
    logic [24:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [24:0] w_sh;
    logic [25:0] w_sub;

    assign w_sh  = {r_rem[23:0], r_num[31]};
    assign w_sub = {1'b0, w_sh} - {2'b0, i_den};
    assign o_quo = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_rem  <= '0;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                if (!w_sub[25]) begin
                    r_rem <= w_sub[24:0];
                    r_num <= {r_num[30:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_num <= {r_num[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/nccr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nccr_back #(
    parameter int MAX_RAMP_POINTS = 30
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  nccr_pkg::t_note           i_note,
    input  wire  [6:0]                i_init,
    input  wire  [8:0]                i_density,
    input  wire  [23:0]               i_atk,
    input  wire  [23:0]               i_dcy,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [6:0]                o_value,
    output logic [33:0]               o_time,
    output logic                      o_last,
    output logic                      o_trunc
);
    localparam int PW = $clog2(MAX_RAMP_POINTS + 1);

    nccr_pkg::t_state r_state, n_state;
    nccr_pkg::t_note  r_note;
    logic [12:0] r_step;
    logic [24:0] r_k;
    logic [PW-1:0] r_pts;
    logic          r_trunc;
    logic [6:0]    r_range;
    logic          r_up;
    logic          w_dstart, w_ddone;
    logic [31:0]   w_quo;
    logic [24:0]   w_num_k;
    logic [23:0]   w_den;
    logic [31:0]   w_prod;
    logic [8:0]    w_vsum;
    logic [6:0]    w_rv;
    logic          r_eq;
    logic [32:0]   w_end;
    logic [12:0]   w_step;
    logic [24:0]   w_lim;
    logic          w_skip;
    logic          r_up_phase;
    logic          r_hold;

    assign w_end   = {1'b0, r_note.start} + {1'b0, r_note.len};
    assign w_num_k = r_k;
    assign w_prod  = 32'(w_num_k) * 32'(r_range);
    assign w_den   = (r_state == nccr_pkg::S_ATK_DIV) ? i_atk : i_dcy;
    assign o_ready = (r_state == nccr_pkg::S_IDLE);
    assign w_step  = 13'((i_density == 9'd0 ? 9'd1 : i_density)) * 13'd10;
    assign w_lim   = 25'(r_step) * 25'(MAX_RAMP_POINTS);
    assign w_skip  = (r_k != 25'd0) && !(r_k <= {1'b0, r_note.start[23:0]} ||
                                         r_note.start[31:24] != 8'd0);

    nccr_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_prod), .i_den(w_den), .o_done(w_ddone), .o_quo(w_quo)
    );

    // ramp value from quotient; quotient <= range so no overflow beyond 8 bits
    always_comb begin
        w_vsum = 9'd0;
        w_rv = i_init;
        if (!r_eq) begin
            if (r_up) begin
                w_vsum = {2'b0, r_note.vel} - w_quo[8:0];
                w_rv = w_vsum[8] ? 7'd0 : w_vsum[6:0];
            end else begin
                w_vsum = {2'b0, r_note.vel} + w_quo[8:0];
                w_rv = (w_vsum > 9'd127) ? nccr_pkg::VEL_MAX : w_vsum[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= nccr_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        w_dstart = 1'b0;
        unique case (r_state)
            nccr_pkg::S_IDLE:     if (i_valid) n_state = nccr_pkg::S_ATK_SKIP;
            nccr_pkg::S_ATK_SKIP: if (!w_skip) n_state = nccr_pkg::S_HEAD;
            nccr_pkg::S_HEAD:     if (o_valid && i_ready) n_state = nccr_pkg::S_ATK_PT;
            nccr_pkg::S_ATK_PT: begin
                if (r_k == 25'd0) n_state = nccr_pkg::S_VEL;
                else if (r_pts == PW'(MAX_RAMP_POINTS)) n_state = nccr_pkg::S_VEL;
                else begin
                    w_dstart = 1'b1;
                    n_state = nccr_pkg::S_ATK_DIV;
                end
            end
            nccr_pkg::S_ATK_DIV: if (w_ddone) n_state = nccr_pkg::S_EMIT;
            nccr_pkg::S_VEL:     if (o_valid && i_ready) n_state = nccr_pkg::S_DCY_PT;
            nccr_pkg::S_DCY_PT: begin
                if (r_k >= {1'b0, i_dcy}) n_state = nccr_pkg::S_TAIL;
                else if (r_pts == PW'(MAX_RAMP_POINTS)) n_state = nccr_pkg::S_TAIL;
                else begin
                    w_dstart = 1'b1;
                    n_state = nccr_pkg::S_DCY_DIV;
                end
            end
            nccr_pkg::S_DCY_DIV: if (w_ddone) n_state = nccr_pkg::S_EMIT;
            nccr_pkg::S_EMIT: begin
                if (o_valid && i_ready)
                    n_state = r_up_phase ? nccr_pkg::S_ATK_PT : nccr_pkg::S_DCY_PT;
            end
            nccr_pkg::S_TAIL:    if (o_valid && i_ready) n_state = nccr_pkg::S_IDLE;
            default:             n_state = nccr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_hold  <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                nccr_pkg::S_IDLE: if (i_valid) begin
                    r_note  <= i_note;
                    r_step  <= w_step;
                    r_k     <= ({1'b0, i_atk} > {12'b0, w_step}) ?
                               {1'b0, i_atk} - {12'b0, w_step} : 25'd0;
                    r_eq    <= (i_note.vel == i_init);
                    r_up    <= (i_init < i_note.vel);
                    r_range <= (i_init < i_note.vel) ? i_note.vel - i_init
                                                     : i_init - i_note.vel;
                    r_trunc <= 1'b0;
                end
                nccr_pkg::S_ATK_SKIP: begin
                    if (w_skip)
                        r_k <= (r_k > {12'b0, r_step}) ? r_k - {12'b0, r_step} : 25'd0;
                    else
                        r_trunc <= (r_k > w_lim) || ({1'b0, i_dcy} > w_lim);
                end
                nccr_pkg::S_HEAD: begin
                    if (!r_hold) begin
                        o_valid <= 1'b1;
                        o_value <= i_init;
                        o_time  <= (r_note.start > {8'b0, i_atk}) ?
                                   {2'b0, r_note.start - {8'b0, i_atk}} : 34'd0;
                        o_last  <= 1'b0;
                        r_hold  <= 1'b1;
                    end else if (i_ready) begin
                        r_hold <= 1'b0;
                        r_pts  <= '0;
                    end
                end
                nccr_pkg::S_ATK_PT: r_up_phase <= 1'b1;
                nccr_pkg::S_DCY_PT: r_up_phase <= 1'b0;
                nccr_pkg::S_ATK_DIV: if (w_ddone) begin
                    o_valid <= 1'b1;
                    o_value <= w_rv;
                    o_time  <= {2'b0, r_note.start - {7'b0, r_k}};
                    o_last  <= 1'b0;
                    r_pts   <= r_pts + PW'(1);
                    r_k     <= (r_k > {12'b0, r_step}) ? r_k - {12'b0, r_step} : 25'd0;
                end
                nccr_pkg::S_DCY_DIV: if (w_ddone) begin
                    o_valid <= 1'b1;
                    o_value <= w_rv;
                    o_time  <= {1'b0, w_end} + {9'b0, r_k};
                    o_last  <= 1'b0;
                    r_pts   <= r_pts + PW'(1);
                    r_k     <= r_k + {12'b0, r_step};
                end
                nccr_pkg::S_VEL: begin
                    if (!r_hold) begin
                        o_valid <= 1'b1;
                        o_value <= r_note.vel;
                        o_time  <= {2'b0, r_note.start};
                        o_last  <= 1'b0;
                        r_hold  <= 1'b1;
                    end else if (i_ready) begin
                        r_hold <= 1'b0;
                        r_k <= '0;
                        r_pts <= '0;
                    end
                end
                nccr_pkg::S_TAIL: begin
                    if (!r_hold) begin
                        o_valid <= 1'b1;
                        o_value <= i_init;
                        o_time  <= {1'b0, w_end} + {10'b0, i_dcy};
                        o_last  <= 1'b1;
                        r_hold  <= 1'b1;
                    end else if (i_ready) begin
                        r_hold <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_trunc = r_trunc;
endmodule
`default_nettype wire

// ===== rtl/core/note_to_controller_ramp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Note to controller ramp.
// Channels: note input (velocity, start, length), controller event output,
// and a configuration write channel (index 0..4: controller number, initial
// value, density, attack length, decay length; other indexes ignored).
// Each note yields 3 to 2*MAX_RAMP_POINTS+3 events, last_event on the final one.
// Each ramp point waits on the serial 32-bit divider; head, velocity and tail
// events need no division. Attack points beyond the start time are skipped
// one step per cycle before the head event.
// A two-entry note queue decouples note intake from event generation.
// ramp_truncated is valid on every event of each series.
// Reset (synchronous, active low) restores register defaults and empties
// the queue. A stalled receiver holds the current event; generation waits.
module note_to_controller_ramp #(
    parameter int MAX_RAMP_POINTS = 30
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    nccr_note_if.sink        i_note,
    nccr_cfg_if.sink         i_cfg,
    nccr_cc_if.source        o_cc
);
    logic [6:0]  r_cc_num, r_init;
    logic [8:0]  r_density;
    logic [23:0] r_atk, r_dcy;
    logic        w_qv, w_qr;
    nccr_pkg::t_note w_qn;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_num  <= nccr_pkg::CC_RST;
            r_init    <= '0;
            r_density <= nccr_pkg::DENSITY_RST;
            r_atk     <= nccr_pkg::ATTACK_RST;
            r_dcy     <= nccr_pkg::DECAY_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                nccr_pkg::REG_CC_NUMBER: r_cc_num  <= i_cfg.data[6:0];
                nccr_pkg::REG_INIT_VAL:  r_init    <= i_cfg.data[6:0];
                nccr_pkg::REG_DENSITY:   r_density <= i_cfg.data[8:0];
                nccr_pkg::REG_ATTACK:    r_atk     <= i_cfg.data;
                nccr_pkg::REG_DECAY:     r_dcy     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    nccr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_note.valid), .o_ready(i_note.ready), .i_note(i_note.note_payload),
        .o_valid(w_qv), .i_ready(w_qr), .o_note(w_qn)
    );

    nccr_back #(.MAX_RAMP_POINTS(MAX_RAMP_POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_note(w_qn),
        .i_init(r_init), .i_density(r_density), .i_atk(r_atk), .i_dcy(r_dcy),
        .o_valid(o_cc.valid), .i_ready(o_cc.ready),
        .o_value(o_cc.cc_value), .o_time(o_cc.cc_time),
        .o_last(o_cc.last_event), .o_trunc(o_cc.ramp_truncated)
    );

    assign o_cc.cc_number = r_cc_num;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    localparam int MAX_PTS    = 30;
    localparam int CYCLE_CAP  = 20000000;
    localparam int SETTLE     = 50;
    localparam int LONG_HOLD  = 3000;

    typedef struct {
        logic [nccr_pkg::VEL_W-1:0] num;
        logic [nccr_pkg::VEL_W-1:0] val;
        logic [nccr_pkg::OUT_W-1:0] tm;
        logic                       last;
        logic                       trunc;
    } t_cc_event;

    logic i_clk;
    logic i_rst_n;

    nccr_note_if note_ch();
    nccr_cfg_if  cfg_ch();
    nccr_cc_if   cc_ch();

    note_to_controller_ramp #(.MAX_RAMP_POINTS(MAX_PTS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_note  (note_ch),
        .i_cfg   (cfg_ch),
        .o_cc    (cc_ch)
    );

    // register shadow
    logic [nccr_pkg::VEL_W-1:0] cur_cc;
    logic [nccr_pkg::VEL_W-1:0] cur_init;
    logic [nccr_pkg::DEN_W-1:0] cur_density;
    logic [nccr_pkg::LEN_W-1:0] cur_attack;
    logic [nccr_pkg::LEN_W-1:0] cur_decay;

    t_cc_event pending_events[$];
    int        errors;
    int        cycles;
    bit        idle_on;
    logic      hold_on;
    int        cc_wait;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        $display("mismatch %s: got %0d expected %0d (event queue %0d)",
                 what, got, want, pending_events.size());
        errors++;
    endtask

    function automatic logic [nccr_pkg::VEL_W-1:0] ramp_point(input int vel, input int init,
                                                              input longint unsigned k,
                                                              input longint unsigned span);
        longint unsigned rng;
        longint unsigned d;
        longint          v;
        if (span == 0 || vel == init) return init[nccr_pkg::VEL_W-1:0];
        rng = (vel > init) ? longint'(vel - init) : longint'(init - vel);
        d = (rng * k) / span;
        v = (init < vel) ? longint'(vel) - longint'(d) : longint'(vel) + longint'(d);
        if (v < 0) v = 0;
        if (v > 127) v = 127;
        return v[nccr_pkg::VEL_W-1:0];
    endfunction

    // expected event series for one note under the current registers
    task automatic predict_series(input int vel, input longint unsigned start,
                                  input longint unsigned dur);
        longint unsigned atk;
        longint unsigned dcy;
        longint unsigned stp;
        longint unsigned fin;
        longint unsigned i0;
        longint unsigned k;
        logic [nccr_pkg::VEL_W-1:0] vals[$];
        longint unsigned  tms[$];
        bit   trunc;
        int   pts;
        t_cc_event ev;
        atk = cur_attack;
        dcy = cur_decay;
        stp = ((cur_density == 0) ? 1 : cur_density) * 10;
        fin = start + dur;
        trunc = 0;
        vals.insert(vals.size(), cur_init);
        tms.insert(tms.size(), start > atk ? start - atk : 0);
        if (atk > stp) begin
            i0 = 1;
            if (atk - stp > start) i0 = (atk - start + stp - 1) / stp;
            k = (stp * i0 < atk) ? atk - stp * i0 : 0;
            pts = 0;
            while (k > 0 && pts < MAX_PTS) begin
                vals.insert(vals.size(), ramp_point(vel, cur_init, k, atk));
                tms.insert(tms.size(), start - k);
                pts++;
                k = (k > stp) ? k - stp : 0;
            end
            if (k > 0) trunc = 1;
        end
        vals.insert(vals.size(), vel[nccr_pkg::VEL_W-1:0]);
        tms.insert(tms.size(), start);
        k = 0;
        pts = 0;
        while (k < dcy && pts < MAX_PTS) begin
            vals.insert(vals.size(), ramp_point(vel, cur_init, k, dcy));
            tms.insert(tms.size(), fin + k);
            pts++;
            k += stp;
        end
        if (k < dcy) trunc = 1;
        vals.insert(vals.size(), cur_init);
        tms.insert(tms.size(), fin + dcy);
        foreach (vals[i]) begin
            ev.num   = cur_cc;
            ev.val   = vals[i];
            ev.tm    = tms[i][nccr_pkg::OUT_W-1:0];
            ev.last  = (i == vals.size() - 1);
            ev.trunc = trunc;
            pending_events.insert(pending_events.size(), ev);
        end
    endtask

    // event receiver and checker
    always @(posedge i_clk) begin
        t_cc_event want;
        if (i_rst_n) begin
            if (cc_ch.valid && cc_ch.ready) begin
                if (pending_events.size() == 0) begin
                    report("unexpected event time", cc_ch.cc_time, 0);
                end else begin
                    want = pending_events.pop_front();
                    if (cc_ch.cc_number !== want.num)
                        report("cc_number", cc_ch.cc_number, want.num);
                    if (cc_ch.cc_value !== want.val)
                        report("cc_value", cc_ch.cc_value, want.val);
                    if (cc_ch.cc_time !== want.tm)
                        report("cc_time", cc_ch.cc_time, want.tm);
                    if (cc_ch.last_event !== want.last)
                        report("last_event", cc_ch.last_event, want.last);
                    if (cc_ch.ramp_truncated !== want.trunc)
                        report("ramp_truncated", cc_ch.ramp_truncated, want.trunc);
                end
                cc_wait = idle_on ? $urandom_range(0, 17) : 0;
            end else if (cc_wait > 0) begin
                cc_wait--;
            end
            cc_ch.ready <= !hold_on && (cc_wait == 0);
        end
    end

    task automatic write_reg(input logic [nccr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nccr_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            nccr_pkg::REG_CC_NUMBER: cur_cc      = data[nccr_pkg::VEL_W-1:0];
            nccr_pkg::REG_INIT_VAL:  cur_init    = data[nccr_pkg::VEL_W-1:0];
            nccr_pkg::REG_DENSITY:   cur_density = data[nccr_pkg::DEN_W-1:0];
            nccr_pkg::REG_ATTACK:    cur_attack  = data[nccr_pkg::LEN_W-1:0];
            nccr_pkg::REG_DECAY:     cur_decay   = data[nccr_pkg::LEN_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input int cc, input int init, input int dens,
                            input int atk, input int dcy);
        write_reg(nccr_pkg::REG_CC_NUMBER, nccr_pkg::CFG_DATA_W'(cc));
        write_reg(nccr_pkg::REG_INIT_VAL, nccr_pkg::CFG_DATA_W'(init));
        write_reg(nccr_pkg::REG_DENSITY, nccr_pkg::CFG_DATA_W'(dens));
        write_reg(nccr_pkg::REG_ATTACK, nccr_pkg::CFG_DATA_W'(atk));
        write_reg(nccr_pkg::REG_DECAY, nccr_pkg::CFG_DATA_W'(dcy));
    endtask

    task automatic send_note(input int vel, input logic [nccr_pkg::TIME_W-1:0] start,
                             input logic [nccr_pkg::TIME_W-1:0] dur);
        int gap;
        nccr_pkg::t_note n;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            note_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        n.vel   = vel[nccr_pkg::VEL_W-1:0];
        n.start = start;
        n.len   = dur;
        note_ch.valid        <= 1'b1;
        note_ch.note_payload <= n;
        @(posedge i_clk);
        while (!note_ch.ready) @(posedge i_clk);
        predict_series(vel, start, dur);
    endtask

    task automatic drain();
        note_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_defaults();
        send_note(0, 0, 0);
        send_note(127, 50, 1000);
        send_note(64, 1000, 32'hFFFF_FFFF);
        send_note(127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_note(0, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();
    endtask

    task automatic test_reg_extremes();
        // upper data bits must be dropped
        set_regs(24'hFFFF_FF, 24'hFFFF_FF, 0, 0, 0);
        send_note(0, 0, 0);
        send_note(127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        set_regs(0, 0, 400, 24'hFF_FFFF, 24'hFF_FFFF);
        send_note(127, 0, 5);
        send_note(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_note(0, 20_000_000, 100);
        drain();
        set_regs(5, 127, 511, 100_000, 50_000);
        send_note(127, 200_000, 10);
        send_note(0, 200_000, 10);
        drain();
        // writes to unused indexes are ignored
        write_reg(nccr_pkg::REG_DECAY + 3'd1, 24'hFF_FFFF);
        write_reg(nccr_pkg::REG_DECAY + 3'd2, '0);
        write_reg(nccr_pkg::REG_DECAY + 3'd3, 24'h12_3456);
        send_note(90, 123_456, 789);
        drain();
    endtask

    task automatic test_truncation();
        set_regs(42, 20, 1, 400, 300);
        send_note(100, 10_000, 50);
        send_note(100, 250, 50);
        drain();
        set_regs(42, 100, 1, 300, 301);
        send_note(3, 10_000, 50);
        send_note(100, 10_000, 0);
        drain();
    endtask

    task automatic random_regs();
        int dens;
        int atk;
        int dcy;
        dens = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 30);
        case ($urandom_range(0, 3))
            0: atk = $urandom_range(0, 24'hFF_FFFF);
            1: atk = 0;
            default: atk = $urandom_range(0, ((dens == 0) ? 1 : dens) * 10 * 35);
        endcase
        case ($urandom_range(0, 3))
            0: dcy = $urandom_range(0, 24'hFF_FFFF);
            1: dcy = 0;
            default: dcy = $urandom_range(0, ((dens == 0) ? 1 : dens) * 10 * 35);
        endcase
        set_regs($urandom, $urandom, dens, atk, dcy);
    endtask

    task automatic random_note();
        int vel;
        logic [nccr_pkg::TIME_W-1:0] start;
        logic [nccr_pkg::TIME_W-1:0] dur;
        int stp;
        vel = ($urandom_range(0, 7) == 0) ? cur_init : $urandom_range(0, 127);
        stp = ((cur_density == 0) ? 1 : cur_density) * 10;
        start = $urandom;
        // a small start is kept to cases where the skipped steps stay few
        if ($urandom_range(0, 3) == 0 && cur_attack / stp < 5000)
            start = $urandom_range(0, cur_attack + stp);
        if (start < cur_attack && cur_attack / stp >= 5000)
            start = start | 32'h0100_0000;
        dur = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 5000);
        send_note(vel, start, dur);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 10; ph++) begin
            idle_on = (ph % 3 != 1);
            random_regs();
            for (int j = 0; j < 25; j++) random_note();
            drain();
        end
        idle_on = 1;
    endtask

    task automatic test_backpressure();
        set_regs(11, 30, 3, 200, 150);
        fork
            begin
                hold_on <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        join_none
        for (int j = 0; j < 8; j++) random_note();
        drain();
    endtask

    initial begin
        errors        = 0;
        cycles        = 0;
        idle_on       = 1;
        cc_wait       = 0;
        hold_on       = 1'b0;
        i_rst_n       = 1'b0;
        note_ch.valid = 1'b0;
        note_ch.note_payload = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        cc_ch.ready   = 1'b0;
        cur_cc        = nccr_pkg::CC_RST;
        cur_init      = '0;
        cur_density   = nccr_pkg::DENSITY_RST;
        cur_attack    = nccr_pkg::ATTACK_RST;
        cur_decay     = nccr_pkg::DECAY_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_reg_extremes();
        test_truncation();
        test_backpressure();
        test_random();

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending_events.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
